// File: sv/fsa_pkg.sv
// Package for the fragmented sparse array: sizes, codes and state types.
`timescale 1ns / 1ps
package fsa_pkg;
   localparam int MaxFrag   = 16;
   localparam int MaxCells  = 16;
   localparam int CellTotal = MaxFrag * MaxCells;
   localparam int FragW     = $clog2(MaxFrag);
   localparam int CellW     = $clog2(MaxCells);
   localparam int SlotW     = $clog2(CellTotal);
   localparam int FillW     = $clog2(MaxCells + 1);
   localparam int CountW    = $clog2(CellTotal + 1);
   localparam int LiveW     = $clog2(MaxFrag + 1);

   typedef enum logic [2:0] {
      MODE_SET = 3'd0, MODE_GET = 3'd1, MODE_DEL = 3'd2,
      MODE_CONTAINS = 3'd3, MODE_ISSET = 3'd4, MODE_CLEAR = 3'd5
   } mode_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_UNSET = 2'd2;

   localparam logic CSR_FRAG_COUNT = 1'b0;
   localparam logic CSR_CELLS      = 1'b1;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_DIV   = 7'b0000010,
      S_READ  = 7'b0000100,
      S_EXEC  = 7'b0001000,
      S_SCAN  = 7'b0010000,
      S_CLEAR = 7'b0100000,
      S_RESP  = 7'b1000000
   } state_type;
endpackage

// File: sv/fragmented_sparse_array_top.sv
// Top level of the fragmented sparse array.
`timescale 1ns / 1ps
// One item at a time. The index is split by a restoring divider, one quotient bit a
// cycle; set, get, delete and is-set then pass through S_READ for the value memory
// read and S_EXEC for the update. Contains-key walks every slot of the configured
// fragments through one comparator, one slot a cycle, until a match or the last
// slot. Clear, and any configuration write, clear the valid bits and fill
// counters at once. The response register frees req_ready once the result is taken.
module fragmented_sparse_array_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [2:0]   req_mode,
   input  logic signed [9:0]  req_index,
   input  logic signed [31:0] req_key,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [1:0]   rsp_status,
   output logic signed [31:0] rsp_value,
   output logic         rsp_hit,
   output logic [8:0]   rsp_stored_count,
   output logic [4:0]   rsp_live_fragment_total,
   output logic [8:0]   rsp_allocated_cells,
   input  logic         csr_write,
   input  logic [0:0]   csr_index,
   input  logic [4:0]   csr_data
);
   import fsa_pkg::*;

   state_type state_ff, state_in;
   logic [4:0] fc_ff, cpf_ff;
   logic [CellTotal-1:0] valid_ff;
   logic [FillW-1:0] fill_ff [MaxFrag];
   logic [CountW-1:0] total_ff;
   logic [LiveW-1:0] live_ff;
   logic [31:0] mem [CellTotal];
   logic [31:0] rd_ff;

   logic [2:0] mode_ff;
   logic [9:0] idx_ff;
   logic [31:0] key_ff;
   logic [9:0] rem_ff;
   logic [9:0] quo_ff;
   logic [3:0] bit_ff;
   logic in_range_ff;
   logic [FragW-1:0] sf_ff;
   logic [CellW-1:0] sc_ff;
   logic found_ff;

   logic [1:0] st_ff;
   logic [31:0] val_ff;
   logic hit_ff;

   logic [4:0] fc, cpf;
   assign fc  = (fc_ff == 5'd0) ? 5'd1 : (fc_ff > 5'(MaxFrag)) ? 5'(MaxFrag) : fc_ff;
   assign cpf = (cpf_ff == 5'd0) ? 5'd1 :
                (cpf_ff > 5'(MaxCells)) ? 5'(MaxCells) : cpf_ff;

   logic [FragW-1:0] frag;
   logic [SlotW-1:0] slot, scan_slot;
   assign frag = quo_ff[FragW-1:0];
   assign slot = {frag, rem_ff[CellW-1:0]};
   assign scan_slot = {sf_ff, sc_ff};

   // one restoring divide step
   logic [10:0] trial;
   logic [9:0]  rem_sh;
   assign rem_sh = {rem_ff[8:0], idx_ff[bit_ff]};
   assign trial = {1'b0, rem_sh} - {6'd0, cpf};

   assign req_ready = state_ff == S_IDLE && !rsp_valid;
   logic clear_all;
   assign clear_all = csr_write || state_ff == S_CLEAR;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid && req_ready) begin
            if (req_mode == MODE_CONTAINS) state_in = S_SCAN;
            else if (req_mode == MODE_CLEAR) state_in = S_CLEAR;
            else if (req_mode > MODE_CLEAR) state_in = S_RESP;
            else state_in = S_DIV;
         end
         S_DIV:   if (bit_ff == 4'd0) state_in = S_READ;
         S_READ:  state_in = S_EXEC;
         S_EXEC:  state_in = S_RESP;
         S_SCAN:  if (found_ff || (sc_ff == CellW'(cpf - 5'd1) &&
                      sf_ff == FragW'(fc - 5'd1))) state_in = S_RESP;
         S_CLEAR: state_in = S_RESP;
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fc_ff <= 5'd16;
         cpf_ff <= 5'd16;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            if (csr_index == CSR_FRAG_COUNT) fc_ff <= csr_data;
            else cpf_ff <= csr_data;
         end
         if (state_ff == S_RESP) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
      end
   end

   // counters and valid bits
   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         valid_ff <= '0;
         total_ff <= '0;
         live_ff <= '0;
         for (int i = 0; i < MaxFrag; i++) fill_ff[i] <= '0;
      end else if (state_ff == S_EXEC && in_range_ff) begin
         if (mode_ff == MODE_SET && !valid_ff[slot]) begin
            valid_ff[slot] <= 1'b1;
            fill_ff[frag] <= fill_ff[frag] + FillW'(1);
            total_ff <= total_ff + CountW'(1);
            if (fill_ff[frag] == '0) live_ff <= live_ff + LiveW'(1);
         end else if (mode_ff == MODE_DEL && valid_ff[slot]) begin
            valid_ff[slot] <= 1'b0;
            fill_ff[frag] <= fill_ff[frag] - FillW'(1);
            total_ff <= total_ff - CountW'(1);
            if (fill_ff[frag] == FillW'(1)) live_ff <= live_ff - LiveW'(1);
         end
      end
   end

   // value memory: one port, registered read
   always_ff @(posedge clock) begin
      if (state_ff == S_EXEC && in_range_ff && mode_ff == MODE_SET) mem[slot] <= key_ff;
      rd_ff <= mem[state_ff == S_SCAN ? scan_slot : slot];
   end

   logic scan_ok_ff;
   logic [31:0] last_inc;
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: if (req_valid && req_ready) begin
            mode_ff <= req_mode;
            idx_ff <= req_index;
            key_ff <= req_key;
            rem_ff <= '0;
            quo_ff <= '0;
            bit_ff <= 4'd9;
            sf_ff <= '0;
            sc_ff <= '0;
            found_ff <= 1'b0;
            scan_ok_ff <= 1'b0;
            st_ff <= ST_OK;
            val_ff <= '0;
            hit_ff <= 1'b0;
         end
         S_DIV: begin
            if (!trial[10]) begin
               rem_ff <= trial[9:0];
               quo_ff <= {quo_ff[8:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[8:0], 1'b0};
            end
            bit_ff <= bit_ff - 4'd1;
            in_range_ff <= !idx_ff[9] && ({1'b0, idx_ff} < 11'(fc * cpf));
         end
         S_EXEC: begin
            if (!in_range_ff) st_ff <= ST_RANGE;
            else if (mode_ff == MODE_GET) begin
               if (valid_ff[slot]) begin val_ff <= rd_ff; hit_ff <= 1'b1; end
               else st_ff <= ST_UNSET;
            end else if (mode_ff == MODE_DEL) begin
               if (!valid_ff[slot]) st_ff <= ST_UNSET;
            end else if (mode_ff == MODE_ISSET) hit_ff <= valid_ff[slot];
         end
         S_SCAN: begin
            // rd_ff lags one slot; compare the slot read last cycle
            scan_ok_ff <= valid_ff[scan_slot];
            if (scan_ok_ff && rd_ff == key_ff) found_ff <= 1'b1;
            if (sc_ff == CellW'(cpf - 5'd1)) begin
               sc_ff <= '0;
               sf_ff <= sf_ff + FragW'(1);
            end else sc_ff <= sc_ff + CellW'(1);
         end
         S_RESP: if (mode_ff == MODE_CONTAINS)
            hit_ff <= found_ff || (scan_ok_ff && rd_ff == key_ff);
         default: ;
      endcase
   end
   assign last_inc = '0;

   assign rsp_status = st_ff;
   assign rsp_value = (val_ff | last_inc);
   assign rsp_hit = hit_ff;
   assign rsp_stored_count = 9'(total_ff);
   assign rsp_live_fragment_total = 5'(live_ff);
   assign rsp_allocated_cells = 9'(live_ff * cpf);

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_resp_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESP |=> rsp_valid) else $error("response lost");
   a_live: assert property (@(posedge clock) disable iff (reset)
      live_ff <= LiveW'(MaxFrag)) else $error("live count overflow");
endmodule
